>>> hdl/bmh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the binary min-heap priority queue.
package bmh_pkg;

  localparam int DEPTH = 64;
  localparam int KEY_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CH_W  = IDX_W + 2;

  typedef enum logic [0:0] {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_WAIT,
    ST_DN_FETCH,
    ST_DN_WAIT,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

>>> hdl/bmh_cmd_if.sv
`timescale 1ns / 1ps
// Command channel: insert or extract beats with their key.
interface bmh_cmd_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [bmh_pkg::KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

>>> hdl/bmh_res_if.sv
`timescale 1ns / 1ps
// Result channel: extracted key, status and fill level.
interface bmh_res_if;
  logic                      valid;
  logic                      ready;
  logic [bmh_pkg::KEY_W-1:0] out_key;
  bmh_pkg::status_t          status;
  logic [bmh_pkg::CNT_W-1:0] fill_count;

  modport source (output valid, output out_key, output status, output fill_count, input ready);
  modport sink   (input valid, input out_key, input status, input fill_count, output ready);
endinterface

>>> hdl/binary_min_heap.sv
`timescale 1ns / 1ps
// Binary min-heap priority queue over a dual-read key RAM.
// Sift: one tree level per cycle in the loop, as each level's children (or parent) come back
//   from the RAM's registered read ports.
// Throughput: one command at a time; the next is taken the cycle after the result is loaded.
// Reset: synchronous active low; empties the heap and drops any pending result.
module binary_min_heap (
  input  logic        clk,
  input  logic        rst_n,
  bmh_cmd_if.sink     in_chan,
  bmh_res_if.source   out_chan
);

  localparam int KW = bmh_pkg::KEY_W;
  localparam int IW = bmh_pkg::IDX_W;
  localparam int CW = bmh_pkg::CNT_W;
  localparam int HW = bmh_pkg::CH_W;

  function automatic logic [HW-1:0] lchild(input logic [IW-1:0] p);
    lchild = {1'b0, p, 1'b1};
  endfunction

  bmh_pkg::state_t  state_r, state_nxt;
  logic [KW-1:0]    key_r, key_nxt;
  logic [KW-1:0]    got_r, got_nxt;
  logic [IW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  bmh_pkg::status_t status_r, status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [KW-1:0]        out_key_r;
  bmh_pkg::status_t     out_status_r;
  logic [CW-1:0]        out_fill_r;

  logic          we;
  logic [IW-1:0] waddr, raddr_a, raddr_b;
  logic [KW-1:0] wdata, rd_a, rd_b;

  logic          accept, full, empty, out_free;
  logic [IW-1:0] slot, slot_par, last_idx, par_idx, gpar_idx;
  logic          up_lt;
  logic [HW-1:0] l_idx, r_idx, pl_idx, cnt_ext;
  logic          r_ok, pick_right, dn_lt, pick_has_kids;
  logic [KW-1:0] pick_val;
  logic [IW-1:0] pick_idx;

  assign in_chan.ready = rst_n && (state_r == bmh_pkg::ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = (count_r == CW'(bmh_pkg::DEPTH));
  assign empty         = (count_r == '0);
  assign out_free      = !out_valid_r || out_chan.ready;

  // insert lands at the slot after the last key; extract pulls the last key
  assign slot     = count_r[IW-1:0];
  assign slot_par = IW'((slot - IW'(1)) >> 1);
  assign last_idx = IW'(count_r - CW'(1));
  assign par_idx  = IW'((pos_r - IW'(1)) >> 1);
  assign gpar_idx = IW'((par_idx - IW'(1)) >> 1);
  assign up_lt    = key_r < rd_a;

  assign cnt_ext       = HW'(count_r);
  assign l_idx         = lchild(pos_r);
  assign r_idx         = l_idx + HW'(1);
  assign r_ok          = r_idx < cnt_ext;
  // equal children: take the right one
  assign pick_right    = r_ok && !(rd_b > rd_a);
  assign pick_val      = pick_right ? rd_b : rd_a;
  assign pick_idx      = pick_right ? r_idx[IW-1:0] : l_idx[IW-1:0];
  assign dn_lt         = pick_val < key_r;
  assign pl_idx        = lchild(pick_idx);
  assign pick_has_kids = pl_idx < cnt_ext;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmh_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_chan.command == bmh_pkg::CMD_INSERT) begin
            if (full)       state_nxt = bmh_pkg::ST_DONE;
            else if (empty) state_nxt = bmh_pkg::ST_FIN;
            else            state_nxt = bmh_pkg::ST_UP_WAIT;
          end else begin
            if (empty) state_nxt = bmh_pkg::ST_DONE;
            else       state_nxt = bmh_pkg::ST_DN_FETCH;
          end
        end
      end
      bmh_pkg::ST_UP_WAIT: begin
        if (up_lt && par_idx != '0) state_nxt = bmh_pkg::ST_UP_WAIT;
        else                        state_nxt = bmh_pkg::ST_FIN;
      end
      bmh_pkg::ST_DN_FETCH: begin
        if (empty)                         state_nxt = bmh_pkg::ST_DONE;
        else if (lchild('0) < cnt_ext)     state_nxt = bmh_pkg::ST_DN_WAIT;
        else                               state_nxt = bmh_pkg::ST_FIN;
      end
      bmh_pkg::ST_DN_WAIT: begin
        if (dn_lt && pick_has_kids) state_nxt = bmh_pkg::ST_DN_WAIT;
        else                        state_nxt = bmh_pkg::ST_FIN;
      end
      bmh_pkg::ST_FIN: state_nxt = bmh_pkg::ST_DONE;
      bmh_pkg::ST_DONE: begin
        if (out_free) state_nxt = bmh_pkg::ST_IDLE;
      end
      default: state_nxt = bmh_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    key_nxt       = key_r;
    got_nxt       = got_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = key_r;
    raddr_a       = gpar_idx;
    raddr_b       = r_idx[IW-1:0];
    unique case (state_r)
      bmh_pkg::ST_IDLE: begin
        if (accept) begin
          got_nxt    = '0;
          status_nxt = bmh_pkg::STAT_OK;
          key_nxt    = in_chan.key;
          if (in_chan.command == bmh_pkg::CMD_INSERT) begin
            pos_nxt = slot;
            raddr_a = slot_par;
            if (full) status_nxt = bmh_pkg::STAT_FULL;
            else      count_nxt  = count_r + CW'(1);
          end else begin
            raddr_a = '0;
            raddr_b = last_idx;
            if (empty) status_nxt = bmh_pkg::STAT_EMPTY;
            else       count_nxt  = count_r - CW'(1);
          end
        end
      end
      bmh_pkg::ST_UP_WAIT: begin
        if (up_lt) begin
          we      = 1'b1;
          wdata   = rd_a;
          pos_nxt = par_idx;
        end
      end
      bmh_pkg::ST_DN_FETCH: begin
        got_nxt = rd_a;
        key_nxt = rd_b;
        pos_nxt = '0;
        raddr_a = IW'(lchild('0));
        raddr_b = IW'(lchild('0) + HW'(1));
      end
      bmh_pkg::ST_DN_WAIT: begin
        raddr_a = pl_idx[IW-1:0];
        raddr_b = IW'(pl_idx + HW'(1));
        if (dn_lt) begin
          we      = 1'b1;
          wdata   = pick_val;
          pos_nxt = pick_idx;
        end
      end
      bmh_pkg::ST_FIN: begin
        we = 1'b1;
      end
      bmh_pkg::ST_DONE: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmh_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    got_r    <= got_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    if (state_r == bmh_pkg::ST_DONE && out_free) begin
      out_key_r    <= got_r;
      out_status_r <= status_r;
      out_fill_r   <= count_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_key    = out_key_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.fill_count = out_fill_r;

  // sift writes and the reads whose data the sift uses never hit the same entry
  bmh_ram #(
    .WIDTH (KW),
    .DEPTH (bmh_pkg::DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

endmodule

>>> hdl/bmh_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/bmh_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the heap queue, bound to the top level.
module bmh_checker (
  input logic       clk,
  input logic       rst_n,
  bmh_cmd_if.sink   in_chan,
  bmh_res_if.source out_chan
);

  localparam int CW = bmh_pkg::CNT_W;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.fill_count <= CW'(bmh_pkg::DEPTH))
    else $error("fill count beyond capacity");

  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == bmh_pkg::STAT_FULL)
      |-> out_chan.fill_count == CW'(bmh_pkg::DEPTH))
    else $error("full status with room left");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == bmh_pkg::STAT_EMPTY)
      |-> (out_chan.fill_count == '0 && out_chan.out_key == '0))
    else $error("empty status with keys held or nonzero key");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("command taken while previous one in progress");

endmodule

bind binary_min_heap bmh_checker u_bmh_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);

>>> verif/binary_min_heap_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the binary min-heap priority queue.
module binary_min_heap_tb;

  localparam int KEY_W          = bmh_pkg::KEY_W;
  localparam int CNT_W          = bmh_pkg::CNT_W;
  localparam int DEPTH          = bmh_pkg::DEPTH;
  localparam int CLK_HALF_NS    = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 16;
  localparam int STALL_CYCLES   = 300;
  localparam int TIMEOUT_CYCLES = 600_000;

  typedef struct {
    logic [KEY_W-1:0]  out_key;
    bmh_pkg::status_t  status;
    logic [CNT_W-1:0]  fill_count;
  } heap_result_t;

  logic clk;
  logic rst_n;

  bmh_cmd_if cmd_bus ();
  bmh_res_if res_bus ();

  binary_min_heap u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cmd_bus.sink),
    .out_chan (res_bus.source)
  );

  // Shadow heap and the results it has promised
  logic [KEY_W-1:0] model_keys [DEPTH];
  int               model_count = 0;
  heap_result_t     heap_results_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left    = 0;

  int error_count = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_full      = 0;
  int n_empty     = 0;
  int peak_fill   = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("FAIL binary_min_heap");
    $finish;
  end

  function automatic heap_result_t predict_heap_op(bmh_pkg::cmd_t op, logic [KEY_W-1:0] key);
    heap_result_t     r;
    int               pos;
    int               up;
    int               lt;
    int               rt;
    int               pick;
    logic [KEY_W-1:0] t;
    r.out_key = '0;
    r.status  = bmh_pkg::STAT_OK;
    if (op == bmh_pkg::CMD_INSERT) begin
      if (model_count >= DEPTH) begin
        r.status = bmh_pkg::STAT_FULL;
      end else begin
        pos = model_count;
        model_keys[pos] = key;
        model_count++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (model_keys[pos] >= model_keys[up]) break;
          t               = model_keys[pos];
          model_keys[pos] = model_keys[up];
          model_keys[up]  = t;
          pos             = up;
        end
      end
    end else if (model_count == 0) begin
      r.status = bmh_pkg::STAT_EMPTY;
    end else begin
      r.out_key     = model_keys[0];
      model_keys[0] = model_keys[model_count - 1];
      model_count--;
      pos = 0;
      forever begin
        lt = 2 * pos + 1;
        rt = lt + 1;
        if (lt >= model_count) break;
        // equal children: take the right one
        if (rt >= model_count || model_keys[rt] > model_keys[lt]) pick = lt;
        else pick = rt;
        if (model_keys[pick] >= model_keys[pos]) break;
        t                = model_keys[pick];
        model_keys[pick] = model_keys[pos];
        model_keys[pos]  = t;
        pos              = pick;
      end
    end
    r.fill_count = CNT_W'(model_count);
    return r;
  endfunction

  // Mix of tiny keys (many ties), keys near the top, and full-range keys
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return KEY_W'($urandom_range(15));
      1: return ~KEY_W'($urandom_range(15));
      default: return KEY_W'($urandom());
    endcase
  endfunction

  task automatic send_cmd(bmh_pkg::cmd_t op, logic [KEY_W-1:0] key);
    heap_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.command <= op;
    cmd_bus.key     <= key;
    do @(posedge clk); while (!cmd_bus.ready);
    r = predict_heap_op(op, key);
    heap_results_due.push_back(r);
    n_sent++;
    if (r.status == bmh_pkg::STAT_FULL) n_full++;
    if (r.status == bmh_pkg::STAT_EMPTY) n_empty++;
    if (model_count > peak_fill) peak_fill = model_count;
  endtask

  task automatic wait_drain();
    cmd_bus.valid <= 1'b0;
    while (heap_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    heap_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (heap_results_due.size() == 0) begin
        $error("result beat with nothing outstanding: out_key %0h status %0d fill_count %0d",
               res_bus.out_key, res_bus.status, res_bus.fill_count);
        error_count++;
      end else begin
        want = heap_results_due.pop_front();
        n_checked++;
        if (res_bus.out_key !== want.out_key) begin
          $error("out_key: expected %0h, actual %0h", want.out_key, res_bus.out_key);
          error_count++;
        end
        if (res_bus.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res_bus.status);
          error_count++;
        end
        if (res_bus.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, actual %0d", want.fill_count, res_bus.fill_count);
          error_count++;
        end
      end
    end
  end

  // Empty extracts, key extremes, ties among children, then pop everything
  task automatic test_extremes();
    send_cmd(bmh_pkg::CMD_EXTRACT, '0);
    send_cmd(bmh_pkg::CMD_EXTRACT, '1);
    send_cmd(bmh_pkg::CMD_INSERT, '1);
    send_cmd(bmh_pkg::CMD_INSERT, '0);
    send_cmd(bmh_pkg::CMD_INSERT, {1'b1, {(KEY_W-1){1'b0}}});
    send_cmd(bmh_pkg::CMD_INSERT, {1'b0, {(KEY_W-1){1'b1}}});
    send_cmd(bmh_pkg::CMD_INSERT, KEY_W'(1));
    repeat (4) send_cmd(bmh_pkg::CMD_INSERT, KEY_W'(5));
    send_cmd(bmh_pkg::CMD_INSERT, ~KEY_W'(1));
    repeat (11) send_cmd(bmh_pkg::CMD_EXTRACT, KEY_W'($urandom()));
    wait_drain();
  endtask

  // Fill to capacity, push against the limit, then drain past empty
  task automatic test_capacity();
    repeat (DEPTH) send_cmd(bmh_pkg::CMD_INSERT, pick_key());
    send_cmd(bmh_pkg::CMD_INSERT, '0);
    send_cmd(bmh_pkg::CMD_INSERT, '1);
    send_cmd(bmh_pkg::CMD_INSERT, pick_key());
    repeat (DEPTH + 2) send_cmd(bmh_pkg::CMD_EXTRACT, pick_key());
    wait_drain();
  endtask

  // Bursts that lean toward inserts or extracts so the fill level wanders
  task automatic test_random(int n_items);
    int done;
    int burst;
    int ins_pct;
    done = 0;
    while (done < n_items) begin
      case ($urandom_range(2))
        0: ins_pct = 80;
        1: ins_pct = 50;
        default: ins_pct = 20;
      endcase
      burst = $urandom_range(10, 60);
      repeat (burst) begin
        if ($urandom_range(99) < ins_pct) send_cmd(bmh_pkg::CMD_INSERT, pick_key());
        else send_cmd(bmh_pkg::CMD_EXTRACT, pick_key());
        done++;
      end
    end
    wait_drain();
  endtask

  // Hold the result side off while commands keep coming, so input stalls
  task automatic test_backpressure();
    int saved_pct;
    saved_pct     = send_idle_pct;
    send_idle_pct = 0;
    stall_left    = STALL_CYCLES;
    repeat (16) begin
      if ($urandom_range(99) < 70) send_cmd(bmh_pkg::CMD_INSERT, pick_key());
      else send_cmd(bmh_pkg::CMD_EXTRACT, pick_key());
    end
    wait_drain();
    send_idle_pct = saved_pct;
  endtask

  initial begin : main_seq
    cmd_bus.valid   = 1'b0;
    cmd_bus.command = bmh_pkg::CMD_INSERT;
    cmd_bus.key     = '0;
    rst_n           = 1'b0;
    send_idle_pct   = 28;
    recv_idle_pct   = 85;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_capacity();
    test_random(520);

    send_idle_pct = 85;
    recv_idle_pct = 28;
    test_random(520);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(520);

    $display("Run covered %0d commands and %0d checked results, peak fill %0d of %0d.",
             n_sent, n_checked, peak_fill, DEPTH);
    $display("Refused inserts on a full heap: %0d; extracts from an empty heap: %0d.",
             n_full, n_empty);
    if (error_count == 0) begin
      $display("PASS binary_min_heap");
    end else begin
      $display("FAIL binary_min_heap");
    end
    $finish;
  end

endmodule
